// ===== hdl/utm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utm_pkg
// Shared types, constants and helpers of the UTF-8 markup truncation block.
// ----------------------------------------------------------------------------
package utm_pkg;

  // Geometry
  localparam int WindowBytesDef = 10;
  localparam int MarkLen        = 10;   // ^c#rrggbb^ and ^b#rrggbb^
  localparam int ResetLen       = 3;    // ^d^
  localparam int LenW           = 4;    // unit length and remaining bytes
  localparam int AddrW          = 3;    // two 32-bit registers
  localparam int DataW          = 32;

  // Register map (byte address / 4)
  localparam logic RegCharLimit  = 1'b0;
  localparam logic RegBufferSize = 1'b1;

  localparam logic [15:0] CharLimitRst  = 16'd64;
  localparam logic [15:0] BufferSizeRst = 16'd256;

  // Characters that drive markup detection
  localparam logic [7:0] ChCaret = 8'h5E;
  localparam logic [7:0] ChHash  = 8'h23;
  localparam logic [7:0] ChB     = 8'h62;
  localparam logic [7:0] ChC     = 8'h63;
  localparam logic [7:0] ChD     = 8'h64;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        out_last;
    logic [15:0] total_length;
  } out_item_t;

  // One queue cell: a byte of the string, a closing mark, or both.
  // A closing mark with a zero byte is a bare end of string.
  typedef struct packed {
    logic       valid;
    logic       term;
    logic [7:0] data;
  } cell_t;

  // Head controls: pop shifts the whole row, strip turns the head into a
  // bare end of string once its byte is handled.
  typedef struct packed {
    logic pop;
    logic strip;
  } head_ctrl_t;

  // Caret classification result
  typedef enum logic [1:0] {
    ClsWait  = 2'd0,
    ClsPlain = 2'd1,
    ClsReset = 2'd2,
    ClsMark  = 2'd3
  } cls_e;

  // Character length from the lead byte: leading ones, at least one.
  function automatic logic [LenW-1:0] lead_len(input logic [7:0] b);
    logic [LenW-1:0] n;
    logic            run;
    n   = '0;
    run = 1'b1;
    for (int i = 7; i >= 0; i--) begin
      if (run && b[i]) begin
        n = n + LenW'(1);
      end else begin
        run = 1'b0;
      end
    end
    if (n == '0) begin
      n = LenW'(1);
    end
    return n;
  endfunction

endpackage

// ===== hdl/utm_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utm_cell
// One stage of the lookahead row. Shifts toward the head on a pop and
// captures a new item when it is the first free stage.
// ----------------------------------------------------------------------------
module utm_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  utm_pkg::cell_t     nxt_i,       // neighbor toward the tail
  input  logic               prv_valid_i, // neighbor toward the head is full
  input  logic               push_i,
  input  utm_pkg::cell_t     item_i,
  input  utm_pkg::head_ctrl_t ctrl_i,
  output utm_pkg::cell_t     cell_o
);
  import utm_pkg::*;

  cell_t cell_q, cell_d;

  // Shift, capture or strip
  always_comb begin
    cell_d = cell_q;
    if (ctrl_i.pop) begin
      if (nxt_i.valid) begin
        cell_d = nxt_i;
      end else if (push_i && cell_q.valid) begin
        cell_d = item_i;
      end else begin
        cell_d = '0;
      end
    end else begin
      if (ctrl_i.strip) begin
        cell_d.data = '0;
      end
      if (!cell_q.valid && prv_valid_i && push_i) begin
        cell_d = item_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

// ===== hdl/utm_head.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utm_head
// Handles the head of the lookahead row: classifies carets, applies the
// truncation rules, counts and drives the output register.
// ----------------------------------------------------------------------------
module utm_head (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  utm_pkg::cell_t       win_i [utm_pkg::MarkLen],
  input  logic [15:0]          char_cap_i,
  input  logic [15:0]          buffer_size_i,
  output utm_pkg::head_ctrl_t  ctrl_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output utm_pkg::out_item_t   out_item_o
);
  import utm_pkg::*;

  logic [15:0]     printable_q, printable_d;
  logic [15:0]     written_q, written_d;
  logic [LenW-1:0] left_q, left_d;
  logic            kept_q, kept_d;
  logic            trunc_q, trunc_d;
  logic            out_valid_q;
  out_item_t       out_item_q;

  logic [MarkLen-1:0] ends_before;
  logic [MarkLen-1:0] avail;
  logic [MarkLen-1:0] stop;
  cls_e               cls;
  cell_t              head;
  logic [LenW-1:0]    len_w;
  logic [16:0]        sum_w;
  logic               fits_w;
  logic               markup_w;
  logic               go_trunc;
  logic               slot_free;
  logic               wait_w;
  logic               act_w;
  logic               emit_w;
  out_item_t          item_w;

  assign head      = win_i[0];
  assign slot_free = !out_valid_q || !out_stall_i;

  // Per position: byte of this string present, or string known to end first
  always_comb begin
    ends_before[0] = 1'b0;
    for (int k = 1; k < MarkLen; k++) begin
      ends_before[k] = ends_before[k-1] | win_i[k-1].term;
    end
    for (int k = 0; k < MarkLen; k++) begin
      avail[k] = win_i[k].valid && (win_i[k].data != '0) && !ends_before[k];
      stop[k]  = ends_before[k] || (win_i[k].valid && (win_i[k].data == '0));
    end
  end

  // Classify a caret at the head
  always_comb begin
    cls = ClsPlain;
    if (!avail[1]) begin
      cls = stop[1] ? ClsPlain : ClsWait;
    end else if (win_i[1].data == ChD) begin
      if (!avail[2]) begin
        cls = stop[2] ? ClsPlain : ClsWait;
      end else begin
        cls = (win_i[2].data == ChCaret) ? ClsReset : ClsPlain;
      end
    end else if ((win_i[1].data == ChB) || (win_i[1].data == ChC)) begin
      if (!avail[2]) begin
        cls = stop[2] ? ClsPlain : ClsWait;
      end else if (win_i[2].data != ChHash) begin
        cls = ClsPlain;
      end else if (!avail[MarkLen-1]) begin
        cls = stop[MarkLen-1] ? ClsPlain : ClsWait;
      end else begin
        cls = (win_i[MarkLen-1].data == ChCaret) ? ClsMark : ClsPlain;
      end
    end
  end

  // Unit length and fit check
  always_comb begin
    if (head.data == ChCaret) begin
      case (cls)
        ClsReset: len_w = LenW'(ResetLen);
        ClsMark:  len_w = LenW'(MarkLen);
        default:  len_w = LenW'(1);
      endcase
    end else begin
      len_w = lead_len(head.data);
    end
  end

  assign markup_w = (head.data == ChCaret) && (len_w > LenW'(1));
  assign sum_w    = {1'b0, written_q} + 17'(len_w);
  assign fits_w   = sum_w < {1'b0, buffer_size_i};
  assign go_trunc = trunc_q || (printable_q >= char_cap_i) || !fits_w;
  assign wait_w   = head.valid && (head.data == ChCaret) && (left_q == '0) &&
                    (cls == ClsWait);
  assign act_w    = head.valid && slot_free && !wait_w;

  // Apply the rules to the head item
  always_comb begin
    printable_d = printable_q;
    written_d   = written_q;
    left_d      = left_q;
    kept_d      = kept_q;
    trunc_d     = trunc_q;
    emit_w      = 1'b0;
    ctrl_o      = '0;
    item_w      = '{out_byte: head.data, out_last: 1'b0, total_length: '0};
    if (act_w) begin
      if (head.data == '0) begin
        // close the string and start over
        emit_w      = 1'b1;
        item_w      = '{out_byte: '0, out_last: 1'b1,
                        total_length: written_q + 16'd1};
        printable_d = '0;
        written_d   = '0;
        left_d      = '0;
        kept_d      = 1'b0;
        trunc_d     = 1'b0;
        ctrl_o.pop  = 1'b1;
      end else begin
        if (left_q != '0) begin
          // continue the current unit
          left_d = left_q - LenW'(1);
          emit_w = kept_q;
        end else begin
          trunc_d = go_trunc;
          if (!go_trunc) begin
            printable_d = printable_q + 16'(!markup_w);
            kept_d      = 1'b1;
            left_d      = len_w - LenW'(1);
            emit_w      = 1'b1;
          end else if (markup_w) begin
            kept_d = fits_w;
            left_d = len_w - LenW'(1);
            emit_w = fits_w;
          end else begin
            kept_d = 1'b0;
            left_d = '0;
          end
        end
        if (emit_w) begin
          written_d = written_q + 16'd1;
        end
        // a closing byte stays as a bare end of string
        ctrl_o.pop   = !head.term;
        ctrl_o.strip = head.term;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      printable_q <= '0;
      written_q   <= '0;
      left_q      <= '0;
      kept_q      <= 1'b0;
      trunc_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      printable_q <= printable_d;
      written_q   <= written_d;
      left_q      <= left_d;
      kept_q      <= kept_d;
      trunc_q     <= trunc_d;
      if (act_w && emit_w) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold the output item until taken
  always_ff @(posedge clk_i) begin
    if (act_w && emit_w) begin
      out_item_q <= item_w;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  a_ctrl_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctrl_o.pop && ctrl_o.strip))
    else $error("head popped and stripped at once");

  a_ctrl_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_o.pop || ctrl_o.strip) |-> slot_free)
    else $error("head advanced with no output slot");

  a_left_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    left_q < LenW'(MarkLen))
    else $error("unit byte count out of range");

  a_close_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (act_w && (head.data == '0)) |=> (written_q == '0) && !trunc_q && out_valid_q)
    else $error("state not cleared after closing item");

  a_total_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_item_q.out_last) |-> (out_item_q.total_length != '0))
    else $error("closing item without length");

endmodule

// ===== hdl/utf8_markup_truncate.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_markup_truncate
// Truncates a UTF-8 string with color markup to a character limit and a
// buffer size, one byte in and at most one byte out per cycle when not stalled.
// ----------------------------------------------------------------------------
//  channel  | handshake                 | payload
//  ---------+---------------------------+--------------------------------
//  input    | in_valid_i / in_stall_o   | in_item_i  (in_byte, in_last)
//  output   | out_valid_o / out_stall_i | out_item_o (out_byte, out_last,
//           |                           |   total_length)
//  config   | APB psel/penable/pready   | char_cap @0x0, buffer_size @0x4
//
// One byte per cycle in and out while the row has a free cell and the output
// is not stalled. A non-NUL closing byte is handled at the head as the byte,
// then the NUL. A caret at the head waits for up to nine later bytes in the
// lookahead row before it is classified; the row of WINDOW_BYTES cells stalls
// the input only when full. No clearing pass after reset.
// ----------------------------------------------------------------------------
module utf8_markup_truncate #(
  parameter int WINDOW_BYTES = utm_pkg::WindowBytesDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  utm_pkg::in_item_t          in_item_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output utm_pkg::out_item_t         out_item_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [utm_pkg::AddrW-1:0]  paddr,
  input  logic [utm_pkg::DataW-1:0]  pwdata,
  output logic [utm_pkg::DataW-1:0]  prdata,
  output logic                       pready
);
  import utm_pkg::*;

  logic [15:0] char_cap_q;
  logic [15:0] buffer_size_q;
  logic        push_w;
  cell_t       item_w;
  head_ctrl_t  head_ctrl;
  cell_t       cells_w   [WINDOW_BYTES];
  cell_t       nxt_w     [WINDOW_BYTES];
  logic        prv_w     [WINDOW_BYTES];
  head_ctrl_t  ctrl_w    [WINDOW_BYTES];
  cell_t       win_w     [MarkLen];

  // Configuration registers
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_cap_q    <= CharLimitRst;
      buffer_size_q <= BufferSizeRst;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        RegCharLimit:  char_cap_q    <= pwdata[15:0];
        RegBufferSize: buffer_size_q <= pwdata[15:0];
        default:       char_cap_q    <= char_cap_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      RegCharLimit:  prdata = DataW'(char_cap_q);
      RegBufferSize: prdata = DataW'(buffer_size_q);
      default:       prdata = '0;
    endcase
  end

  // Accept an item while the row has a free cell
  assign in_stall_o = cells_w[WINDOW_BYTES-1].valid;
  assign push_w     = in_valid_i && !in_stall_o;
  assign item_w     = '{valid: 1'b1,
                        term:  in_item_i.in_last || (in_item_i.in_byte == '0),
                        data:  in_item_i.in_byte};

  // Lookahead row
  for (genvar g = 0; g < WINDOW_BYTES; g++) begin : g_cell
    if (g == WINDOW_BYTES - 1) begin : g_tail
      assign nxt_w[g] = '0;
    end else begin : g_mid
      assign nxt_w[g] = cells_w[g+1];
    end
    if (g == 0) begin : g_head
      assign prv_w[g]  = 1'b1;
      assign ctrl_w[g] = head_ctrl;
    end else begin : g_body
      assign prv_w[g]  = cells_w[g-1].valid;
      assign ctrl_w[g] = '{pop: head_ctrl.pop, strip: 1'b0};
    end

    utm_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .nxt_i       (nxt_w[g]),
      .prv_valid_i (prv_w[g]),
      .push_i      (push_w),
      .item_i      (item_w),
      .ctrl_i      (ctrl_w[g]),
      .cell_o      (cells_w[g])
    );
  end

  for (genvar g = 0; g < MarkLen; g++) begin : g_win
    assign win_w[g] = cells_w[g];
  end

  // Head logic and output register
  utm_head u_head (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .win_i         (win_w),
    .char_cap_i    (char_cap_q),
    .buffer_size_i (buffer_size_q),
    .ctrl_o        (head_ctrl),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_item_o    (out_item_o)
  );

  a_window_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    WINDOW_BYTES >= MarkLen)
    else $error("lookahead row shorter than a markup sequence");

  a_no_hole: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cells_w[0].valid |-> !cells_w[1].valid)
    else $error("gap at the head of the lookahead row");

  a_tail_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_ctrl.pop && !push_w) |=> !cells_w[WINDOW_BYTES-1].valid)
    else $error("tail cell kept after a pop without a new item");

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Feeds strings of UTF-8 text and color markup byte by byte into the
// truncation block over several limit and buffer settings, with random idle
// cycles and back pressure. Every result item is checked field by field
// against a predictor that tracks the lookahead window, the counters and the
// phase of the string in flight, or against the output a directed row gives.
// ----------------------------------------------------------------------------
module tb_top;
  import utm_pkg::*;

  // Directed strings use a few stand-in characters for raw bytes:
  // '@' = 0x00, '$' = 0xFF, '%' = 0x80, '&' = 0xC3, '*' = 0x7F.
  typedef struct {
    string text;      // bytes sent
    bit    end_last;  // set in_last on the final byte
    int    lim;       // character cap
    int    bsz;       // buffer_size
    bit    typed;     // output given below instead of the predictor
    string want;      // kept bytes, closing NUL not included
  } plan_row_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  in_item_t    in_item_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_item_t   out_item_o;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [AddrW-1:0] paddr  = '0;
  logic [DataW-1:0] pwdata = '0;
  logic [DataW-1:0] prdata;
  logic        pready;

  // Predictor state
  logic [7:0]  pend_bytes [WindowBytesDef];
  int unsigned pend_fill;
  int unsigned kept_chars;
  int unsigned kept_bytes;
  int unsigned unit_left;
  bit          unit_on;
  bit          cut_phase;
  int unsigned lim_cfg = CharLimitRst;
  int unsigned buf_cfg = BufferSizeRst;

  out_item_t   due_q [$];
  bit          table_owns = 1'b0;
  bit          calm = 1'b0;
  int          calm_from = 32'h7fff_ffff;
  int          sent_items = 0;
  int          bad_count = 0;
  plan_row_t   plan [11];

  utf8_markup_truncate dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------- predictor

  function automatic void clear_string();
    foreach (pend_bytes[i]) pend_bytes[i] = 8'h00;
    pend_fill  = 0;
    kept_chars = 0;
    kept_bytes = 0;
    unit_left  = 0;
    unit_on    = 1'b0;
    cut_phase  = 1'b0;
  endfunction

  function automatic int utf8_len(logic [7:0] b);
    int n;
    n = 0;
    for (int i = 7; i >= 0 && b[i]; i--) n++;
    return (n == 0) ? 1 : n;
  endfunction

  // Decide what a caret at the head of the window starts.
  function automatic cls_e caret_class(bit ended);
    cls_e short_cls;
    short_cls = ended ? ClsPlain : ClsWait;
    if (pend_fill < 2) return short_cls;
    if (pend_bytes[1] == ChD) begin
      if (pend_fill < 3) return short_cls;
      return (pend_bytes[2] == ChCaret) ? ClsReset : ClsPlain;
    end
    if (pend_bytes[1] == ChB || pend_bytes[1] == ChC) begin
      if (pend_fill < 3) return short_cls;
      if (pend_bytes[2] != ChHash) return ClsPlain;
      if (pend_fill < MarkLen) return short_cls;
      return (pend_bytes[MarkLen-1] == ChCaret) ? ClsMark : ClsPlain;
    end
    return ClsPlain;
  endfunction

  function automatic void keep_byte(logic [7:0] b);
    out_item_t r;
    r.out_byte     = b;
    r.out_last     = 1'b0;
    r.total_length = 16'h0000;
    due_q.push_back(r);
    kept_bytes = (kept_bytes + 1) & 32'hFFFF;
  endfunction

  function automatic void drop_head();
    for (int i = 0; i + 1 < pend_fill; i++) pend_bytes[i] = pend_bytes[i+1];
    pend_fill--;
  endfunction

  // Hand out every window byte whose unit can be decided now.
  function automatic void settle_window(bit ended);
    logic [7:0] b;
    int         len;
    bit         is_mark;
    bit         fits;
    cls_e       cls;
    while (pend_fill > 0) begin
      b = pend_bytes[0];
      if (unit_left > 0) begin
        unit_left--;
        if (unit_on) keep_byte(b);
        drop_head();
        continue;
      end
      if (b == ChCaret) begin
        cls = caret_class(ended);
        if (cls == ClsWait) break;
        len = (cls == ClsMark) ? MarkLen : (cls == ClsReset) ? ResetLen : 1;
      end else begin
        len = utf8_len(b);
      end
      is_mark = (b == ChCaret) && (len > 1);
      fits    = (kept_bytes + len) < buf_cfg;
      if (!cut_phase && (kept_chars >= lim_cfg || !fits)) cut_phase = 1'b1;
      if (!cut_phase) begin
        if (!is_mark) kept_chars++;
        unit_on   = 1'b1;
        unit_left = len - 1;
        keep_byte(b);
      end else if (is_mark) begin
        unit_on   = fits;
        unit_left = len - 1;
        if (fits) keep_byte(b);
      end else begin
        unit_on   = 1'b0;
        unit_left = 0;
      end
      drop_head();
    end
  endfunction

  // Queue the results that one accepted input item causes.
  function automatic void truncate_step(in_item_t it);
    bit        ended;
    out_item_t r;
    ended = it.in_last || (it.in_byte == 8'h00);
    if (it.in_byte != 8'h00 && pend_fill < WindowBytesDef) begin
      pend_bytes[pend_fill] = it.in_byte;
      pend_fill++;
    end
    settle_window(ended);
    if (ended) begin
      r.out_byte     = 8'h00;
      r.out_last     = 1'b1;
      r.total_length = 16'(kept_bytes + 1);
      due_q.push_back(r);
      clear_string();
    end
  endfunction

  // ------------------------------------------------------------------ checker

  function automatic void log_fault(string msg);
    bad_count++;
    if (bad_count <= 10) $display("%0t: %s", $time, msg);
  endfunction

  // Predict on accepted input items first, then check accepted result items.
  always @(posedge clk_i) begin
    int        base;
    out_item_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        base = due_q.size();
        truncate_step(in_item_i);
        if (table_owns) begin
          while (due_q.size() > base) void'(due_q.pop_back());
        end
      end
      if (out_valid_o && !out_stall_i) begin
        if (due_q.size() == 0) begin
          log_fault($sformatf("unexpected item: byte %h last %b total %0d",
                              out_item_o.out_byte, out_item_o.out_last,
                              out_item_o.total_length));
        end else begin
          want = due_q.pop_front();
          if (out_item_o.out_byte !== want.out_byte ||
              out_item_o.out_last !== want.out_last ||
              out_item_o.total_length !== want.total_length) begin
            log_fault($sformatf(
              "mismatch: expected byte %h last %b total %0d, got byte %h last %b total %0d",
              want.out_byte, want.out_last, want.total_length,
              out_item_o.out_byte, out_item_o.out_last, out_item_o.total_length));
          end
        end
      end
    end
  end

  // Stall the output at random, except during the calm stretch.
  always @(negedge clk_i) begin
    out_stall_i <= rst_ni && !calm && ($urandom_range(0, 99) < 20);
  end

  // ------------------------------------------------------------------ drivers

  // Offer one input item; return at the edge that accepts it.
  task automatic push_item(input logic [7:0] b, input bit last);
    int gap;
    calm = (sent_items >= calm_from) && (sent_items < calm_from + 80);
    gap  = (!calm && $urandom_range(0, 99) < 20) ? 1 : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i        <= 1'b1;
    in_item_i.in_byte <= b;
    in_item_i.in_last <= last;
    do @(posedge clk_i); while (in_stall_o);
    sent_items++;
  endtask

  // Drop valid and wait until every result has arrived and the block is idle.
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (due_q.size() != 0) @(negedge clk_i);
    repeat (16) @(negedge clk_i);
  endtask

  task automatic apb_write(input logic regsel, input logic [15:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'({regsel, 2'b00});
    pwdata  <= {16'h0000, value};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_limits(input int lim, input int bsz);
    wait_idle();
    apb_write(RegCharLimit, 16'(lim));
    apb_write(RegBufferSize, 16'(bsz));
    lim_cfg = lim;
    buf_cfg = bsz;
  endtask

  function automatic logic [7:0] decode_char(byte c);
    case (c)
      "@":     return 8'h00;
      "$":     return 8'hFF;
      "%":     return 8'h80;
      "&":     return 8'hC3;
      "*":     return 8'h7F;
      default: return 8'(c);
    endcase
  endfunction

  // Append one unit of text, well formed or not.
  function automatic void add_unit(ref logic [7:0] s [$]);
    string hex;
    int    pick;
    int    n;
    hex  = "0123456789abcdef";
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      s.push_back(8'($urandom_range(32, 126)));
    end else if (pick < 50) begin
      n = $urandom_range(2, 4);
      if (n == 2)      s.push_back(8'hC0 | 8'($urandom_range(0, 31)));
      else if (n == 3) s.push_back(8'hE0 | 8'($urandom_range(0, 15)));
      else             s.push_back(8'hF0 | 8'($urandom_range(0, 7)));
      repeat (n - 1) s.push_back(8'h80 | 8'($urandom_range(0, 63)));
    end else if (pick < 65) begin
      s.push_back(ChCaret);
      s.push_back($urandom_range(0, 1) ? ChB : ChC);
      s.push_back(ChHash);
      repeat (6) s.push_back(8'(hex[$urandom_range(0, 15)]));
      s.push_back(ChCaret);
    end else if (pick < 75) begin
      s.push_back(ChCaret);
      s.push_back(ChD);
      s.push_back(ChCaret);
    end else if (pick < 88) begin
      // broken markup: a caret followed by a sequence that goes wrong
      s.push_back(ChCaret);
      case ($urandom_range(0, 3))
        0: begin
          s.push_back(ChD);
          s.push_back(8'($urandom_range(97, 122)));
        end
        1: begin
          s.push_back(ChC);
          s.push_back(8'($urandom_range(48, 57)));
        end
        2: begin
          s.push_back(ChB);
          s.push_back(ChHash);
          repeat (6) s.push_back(8'(hex[$urandom_range(0, 15)]));
          s.push_back(8'($urandom_range(97, 122)));
        end
        default: ;
      endcase
    end else begin
      s.push_back(8'($urandom_range(1, 255)));
    end
  endfunction

  task automatic send_random_string();
    logic [7:0] s [$];
    bit         end_last;
    repeat ($urandom_range(1, 8)) add_unit(s);
    end_last = $urandom_range(0, 1);
    if (!end_last) s.push_back(8'h00);
    foreach (s[i]) begin
      push_item(s[i], (end_last || $urandom_range(0, 1)) && (i == s.size() - 1));
    end
  endtask

  // ----------------------------------------------------------------- sequence

  initial begin
    int        rand_start;
    int        phase_start;
    int        phase;
    out_item_t r;

    clear_string();
    plan = '{
      '{"@",          1'b1, 64, 256, 1'b1, ""},
      '{"a&@",        1'b0, 64, 256, 1'b1, "a&"},
      '{"*$%",        1'b1, 64, 256, 1'b0, ""},
      '{"^c#0a0b0c^", 1'b1, 64, 256, 1'b0, ""},
      '{"^d^x",       1'b1, 64, 256, 1'b0, ""},
      '{"^q",         1'b1, 64, 256, 1'b0, ""},
      '{"^b#1",       1'b1, 64, 256, 1'b0, ""},
      '{"a^d^",       1'b1, 0,  256, 1'b1, "^d^"},
      '{"ab^x^d^",    1'b1, 1,  256, 1'b0, ""},
      '{"ab^d^",      1'b1, 64, 4,   1'b1, "ab"},
      '{"a",          1'b1, 64, 0,   1'b1, ""}
    };

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed strings
    foreach (plan[k]) begin
      if (plan[k].lim != lim_cfg || plan[k].bsz != buf_cfg) begin
        set_limits(plan[k].lim, plan[k].bsz);
      end
      if (plan[k].typed) begin
        for (int j = 0; j < plan[k].want.len(); j++) begin
          r.out_byte     = decode_char(plan[k].want[j]);
          r.out_last     = 1'b0;
          r.total_length = 16'h0000;
          due_q.push_back(r);
        end
        r.out_byte     = 8'h00;
        r.out_last     = 1'b1;
        r.total_length = 16'(plan[k].want.len() + 1);
        due_q.push_back(r);
      end
      table_owns = plan[k].typed;
      for (int j = 0; j < plan[k].text.len(); j++) begin
        push_item(decode_char(plan[k].text[j]),
                  plan[k].end_last && (j == plan[k].text.len() - 1));
      end
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      table_owns = 1'b0;
    end

    // Random strings over a rotation of settings
    rand_start = sent_items;
    calm_from  = rand_start + $urandom_range(100, 200);
    phase      = 0;
    while (sent_items < rand_start + 360) begin
      case (phase % 7)
        0: set_limits(64, 256);
        1: set_limits(3, 12);
        2: set_limits(0, 30);
        3: set_limits(65535, 65535);
        4: set_limits(2, 1);
        5: set_limits(65535, 0);
        default: set_limits($urandom_range(0, 10), $urandom_range(1, 40));
      endcase
      phase_start = sent_items;
      while (sent_items < phase_start + 55 && sent_items < rand_start + 360) begin
        send_random_string();
      end
      phase++;
    end

    wait_idle();
    repeat (20) @(posedge clk_i);
    if (bad_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Hold a hard limit on run time.
  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
